FILE: sv/scan_code_set2_to_hid_report_defines.svh
// ----------------------------------------------------------------------------
// Scan code to HID report defines
// Assertion macros shared by the scan code to HID report block.
// ----------------------------------------------------------------------------
`ifndef SCAN_CODE_SET2_TO_HID_REPORT_DEFINES_SVH
`define SCAN_CODE_SET2_TO_HID_REPORT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define S2H_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("s2h assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define S2H_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("s2h assertion failed in the next cycle");

`endif

FILE: sv/s2h_pkg.sv
// ----------------------------------------------------------------------------
// Scan code to HID report package
// Prefix states, event codes, scan byte constants and the usage table.
// ----------------------------------------------------------------------------
`default_nettype none

package s2h_pkg;

   localparam int KEY_SLOTS_DEFAULT = 6;
   localparam int SHOWN_SLOTS = 6;

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_F0        = 9'b000000010,
      ST_E0        = 9'b000000100,
      ST_E0F0      = 9'b000001000,
      ST_E1        = 9'b000010000,
      ST_E1_14     = 9'b000100000,
      ST_E1F0      = 9'b001000000,
      ST_E1F0_14   = 9'b010000000,
      ST_E1F0_14F0 = 9'b100000000
   } prefix_state_type;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_MAKE  = 2'd1,
      EV_BREAK = 2'd2
   } key_event_type;

   localparam logic [7:0] CODE_E0          = 8'hE0;
   localparam logic [7:0] CODE_F0          = 8'hF0;
   localparam logic [7:0] CODE_E1          = 8'hE1;
   localparam logic [7:0] CODE_PAUSE_14    = 8'h14;
   localparam logic [7:0] CODE_PAUSE_77    = 8'h77;
   localparam logic [7:0] CODE_FAKE_LSHIFT = 8'h12;
   localparam logic [7:0] CODE_FAKE_RSHIFT = 8'h59;
   localparam logic [7:0] CODE_KEY_83      = 8'h83;
   localparam logic [7:0] CODE_KEY_84      = 8'h84;
   localparam logic [7:0] CODE_BAT_OK      = 8'hAA;
   localparam logic [7:0] CODE_BAT_FAIL    = 8'hFC;
   localparam logic [7:0] CODE_ID_F1       = 8'hF1;
   localparam logic [7:0] CODE_ID_F2       = 8'hF2;
   localparam logic [7:0] CODE_PLAIN_LIMIT = 8'h80;
   localparam logic [7:0] ADDR_PAUSE       = 8'hF7;

   localparam logic [3:0] PAGE_KEYBOARD     = 4'h0;
   localparam logic [3:0] PAGE_KEYBOARD_ALT = 4'h7;
   localparam logic [4:0] MODIFIER_USAGE_HI = 5'b11100;

   localparam logic [15:0] USAGE_ROM [256] = '{
      16'h0000, 16'h0042, 16'h0000, 16'h003E, 16'h003C, 16'h003A, 16'h003B, 16'h0045,
      16'h0068, 16'h0043, 16'h0041, 16'h003F, 16'h003D, 16'h002B, 16'h0035, 16'h0067,
      16'h0069, 16'h00E2, 16'h00E1, 16'h0088, 16'h00E0, 16'h0014, 16'h001E, 16'h0000,
      16'h006A, 16'h0000, 16'h001D, 16'h0016, 16'h0004, 16'h001A, 16'h001F, 16'h0000,
      16'h006B, 16'h0006, 16'h001B, 16'h0007, 16'h0008, 16'h0021, 16'h0020, 16'h008C,
      16'h006C, 16'h002C, 16'h0019, 16'h0009, 16'h0017, 16'h0015, 16'h0022, 16'h0000,
      16'h006D, 16'h0011, 16'h0005, 16'h000B, 16'h000A, 16'h001C, 16'h0023, 16'h0000,
      16'h006E, 16'h0000, 16'h0010, 16'h000D, 16'h0018, 16'h0024, 16'h0025, 16'h0000,
      16'h006F, 16'h0036, 16'h000E, 16'h000C, 16'h0012, 16'h0027, 16'h0026, 16'h0000,
      16'h0070, 16'h0037, 16'h0038, 16'h000F, 16'h0033, 16'h0013, 16'h002D, 16'h0000,
      16'h0071, 16'h0087, 16'h0034, 16'h0000, 16'h002F, 16'h002E, 16'h0000, 16'h0072,
      16'h0039, 16'h00E5, 16'h0028, 16'h0030, 16'h0000, 16'h0031, 16'h0000, 16'h0073,
      16'h0000, 16'h0064, 16'h0093, 16'h0092, 16'h008A, 16'h0000, 16'h002A, 16'h008B,
      16'h0000, 16'h0059, 16'h0089, 16'h005C, 16'h005F, 16'h0085, 16'h0000, 16'h0000,
      16'h0062, 16'h0063, 16'h005A, 16'h005D, 16'h005E, 16'h0060, 16'h0029, 16'h0053,
      16'h0044, 16'h0057, 16'h005B, 16'h0056, 16'h0055, 16'h0061, 16'h0047, 16'h0046,
      16'h0000, 16'h0000, 16'h0000, 16'h0040, 16'h0046, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'hC221, 16'h00E6, 16'h0000, 16'h0000, 16'h00E4, 16'hC0B6, 16'h0000, 16'h0000,
      16'hC22A, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h00E3,
      16'hC227, 16'hC0EA, 16'h0000, 16'hC0E2, 16'h0000, 16'h0000, 16'h0000, 16'h00E7,
      16'hC226, 16'h0000, 16'h0000, 16'hC192, 16'h0000, 16'h0000, 16'h0000, 16'h0065,
      16'hC225, 16'h0000, 16'hC0E9, 16'h0000, 16'hC0CD, 16'h0000, 16'h0000, 16'h1081,
      16'hC224, 16'h0000, 16'hC223, 16'hC0B7, 16'h0000, 16'h0000, 16'h0000, 16'h1082,
      16'hC194, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'hC18A, 16'h0000, 16'h0054, 16'h0000, 16'h0000, 16'hC0B5, 16'h0000, 16'h0000,
      16'hC183, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0058, 16'h0000, 16'h0000, 16'h0000, 16'h1083, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h004D, 16'h0000, 16'h0050, 16'h004A, 16'h0000, 16'h0000, 16'h0000,
      16'h0049, 16'h004C, 16'h0051, 16'h0000, 16'h004F, 16'h0052, 16'h0000, 16'h0048,
      16'h0000, 16'h0000, 16'h004E, 16'h0000, 16'h0046, 16'h004B, 16'h0048, 16'h0000
   };

   function automatic logic [15:0] usage_lookup(input logic [7:0] addr);
      return USAGE_ROM[addr];
   endfunction

endpackage

`default_nettype wire

FILE: sv/s2h_req_if.sv
// ----------------------------------------------------------------------------
// Scan byte channel
// Valid/ready channel that carries one Code Set 2 scan byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface s2h_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] scan_byte;

   modport source (output valid, output scan_byte, input ready);
   modport sink (input valid, input scan_byte, output ready);
endinterface

`default_nettype wire

FILE: sv/s2h_rsp_if.sv
// ----------------------------------------------------------------------------
// Keyboard report channel
// Valid/ready channel that carries the event, error and report after a byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface s2h_rsp_if;
   logic       valid;
   logic       ready;
   logic       error_flag;
   logic [1:0] key_event;
   logic [7:0] modifier_byte;
   logic [7:0] key_slot_0;
   logic [7:0] key_slot_1;
   logic [7:0] key_slot_2;
   logic [7:0] key_slot_3;
   logic [7:0] key_slot_4;
   logic [7:0] key_slot_5;

   modport source (
      output valid, output error_flag, output key_event, output modifier_byte,
      output key_slot_0, output key_slot_1, output key_slot_2,
      output key_slot_3, output key_slot_4, output key_slot_5,
      input ready
   );
   modport sink (
      input valid, input error_flag, input key_event, input modifier_byte,
      input key_slot_0, input key_slot_1, input key_slot_2,
      input key_slot_3, input key_slot_4, input key_slot_5,
      output ready
   );
endinterface

`default_nettype wire

FILE: sv/scan_code_set2_to_hid_report.sv
// ----------------------------------------------------------------------------
// Scan code set 2 to HID keyboard report
// Decodes Code Set 2 prefixes into make and break events and keeps the
// HID modifier byte and key slots up to date.
// ----------------------------------------------------------------------------
//  Channel    Direction  Contents
//  req_chan   in         scan_byte
//  rsp_chan   out        error_flag, key_event, modifier_byte, key_slot_0..5
//
// Each scan byte passes the input register and then the result register on its
// way to its report, with a new byte every cycle while the report is not stalled.
// The usage table read and the slot compares sit between those two registers.
// Reset clears the prefix state, the modifier byte and all key slots.
// A stalled report holds the pipeline; one byte still waits in the input stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "scan_code_set2_to_hid_report_defines.svh"

module scan_code_set2_to_hid_report #(
   parameter int KEY_SLOTS = s2h_pkg::KEY_SLOTS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   s2h_req_if.sink      req_chan,
   s2h_rsp_if.source    rsp_chan
);

   logic                      in_valid_ff;
   logic [7:0]                in_byte_ff;
   logic                      rsp_valid_ff;
   logic                      err_ff;
   logic                      err_in;
   s2h_pkg::key_event_type    ev_ff;
   s2h_pkg::key_event_type    ev_in;
   s2h_pkg::prefix_state_type state_ff;
   s2h_pkg::prefix_state_type state_in;
   logic [7:0]                mod_ff;
   logic [7:0]                mod_in;
   logic [7:0]                slot_ff [KEY_SLOTS];
   logic [7:0]                slot_in [KEY_SLOTS];
   logic [7:0]                shown [s2h_pkg::SHOWN_SLOTS];
   logic                      advance;
   logic                      plain;
   logic [7:0]                addr;
   logic [15:0]               entry;
   logic [3:0]                page;
   logic [7:0]                usage;
   logic                      usable;
   logic [7:0]                mod_bit;
   logic [KEY_SLOTS-1:0]      hit;
   logic [KEY_SLOTS-1:0]      free;
   logic                      taken;

   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      state_in = s2h_pkg::ST_IDLE;
      err_in = 1'b0;
      ev_in = s2h_pkg::EV_NONE;
      addr = in_byte_ff;
      plain = (in_byte_ff < s2h_pkg::CODE_PLAIN_LIMIT)
         || (in_byte_ff inside {s2h_pkg::CODE_KEY_83, s2h_pkg::CODE_KEY_84});
      case (state_ff)
         s2h_pkg::ST_IDLE: begin
            if (in_byte_ff == s2h_pkg::CODE_E0) begin
               state_in = s2h_pkg::ST_E0;
            end else if (in_byte_ff == s2h_pkg::CODE_F0) begin
               state_in = s2h_pkg::ST_F0;
            end else if (in_byte_ff == s2h_pkg::CODE_E1) begin
               state_in = s2h_pkg::ST_E1;
            end else if (plain) begin
               ev_in = s2h_pkg::EV_MAKE;
            end else if (!(in_byte_ff inside {s2h_pkg::CODE_BAT_OK, s2h_pkg::CODE_BAT_FAIL,
                  s2h_pkg::CODE_ID_F1, s2h_pkg::CODE_ID_F2})) begin
               err_in = 1'b1;
            end
         end
         s2h_pkg::ST_E0: begin
            addr = {1'b1, in_byte_ff[6:0]};
            if (in_byte_ff == s2h_pkg::CODE_F0) begin
               state_in = s2h_pkg::ST_E0F0;
            end else if (in_byte_ff inside {s2h_pkg::CODE_FAKE_LSHIFT,
                  s2h_pkg::CODE_FAKE_RSHIFT}) begin
               ev_in = s2h_pkg::EV_NONE;
            end else if (in_byte_ff < s2h_pkg::CODE_PLAIN_LIMIT) begin
               ev_in = s2h_pkg::EV_MAKE;
            end else begin
               err_in = 1'b1;
            end
         end
         s2h_pkg::ST_F0: begin
            if (plain) begin
               ev_in = s2h_pkg::EV_BREAK;
            end else begin
               err_in = 1'b1;
            end
         end
         s2h_pkg::ST_E0F0: begin
            addr = {1'b1, in_byte_ff[6:0]};
            if (in_byte_ff inside {s2h_pkg::CODE_FAKE_LSHIFT, s2h_pkg::CODE_FAKE_RSHIFT}) begin
               ev_in = s2h_pkg::EV_NONE;
            end else if (in_byte_ff < s2h_pkg::CODE_PLAIN_LIMIT) begin
               ev_in = s2h_pkg::EV_BREAK;
            end else begin
               err_in = 1'b1;
            end
         end
         s2h_pkg::ST_E1: begin
            if (in_byte_ff == s2h_pkg::CODE_PAUSE_14) begin
               state_in = s2h_pkg::ST_E1_14;
            end else if (in_byte_ff == s2h_pkg::CODE_F0) begin
               state_in = s2h_pkg::ST_E1F0;
            end
         end
         s2h_pkg::ST_E1_14: begin
            addr = s2h_pkg::ADDR_PAUSE;
            if (in_byte_ff == s2h_pkg::CODE_PAUSE_77) begin
               ev_in = s2h_pkg::EV_MAKE;
            end
         end
         s2h_pkg::ST_E1F0: begin
            if (in_byte_ff == s2h_pkg::CODE_PAUSE_14) begin
               state_in = s2h_pkg::ST_E1F0_14;
            end
         end
         s2h_pkg::ST_E1F0_14: begin
            if (in_byte_ff == s2h_pkg::CODE_F0) begin
               state_in = s2h_pkg::ST_E1F0_14F0;
            end
         end
         s2h_pkg::ST_E1F0_14F0: begin
            addr = s2h_pkg::ADDR_PAUSE;
            if (in_byte_ff == s2h_pkg::CODE_PAUSE_77) begin
               ev_in = s2h_pkg::EV_BREAK;
            end
         end
         default: begin
            state_in = s2h_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      entry = s2h_pkg::usage_lookup(addr);
      page = entry[15:12];
      usage = entry[7:0];
      usable = (ev_in != s2h_pkg::EV_NONE) && (usage != 8'd0)
         && ((page == s2h_pkg::PAGE_KEYBOARD) || (page == s2h_pkg::PAGE_KEYBOARD_ALT));
      mod_bit = 8'd1 << usage[2:0];
      mod_in = mod_ff;
      slot_in = slot_ff;
      taken = 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         hit[i] = slot_ff[i] == usage;
         free[i] = slot_ff[i] == 8'd0;
      end
      if (usable && (usage[7:3] == s2h_pkg::MODIFIER_USAGE_HI)) begin
         if (ev_in == s2h_pkg::EV_MAKE) begin
            mod_in = mod_ff | mod_bit;
         end else begin
            mod_in = mod_ff & ~mod_bit;
         end
      end else if (usable) begin
         for (int i = 0; i < KEY_SLOTS; i++) begin
            if ((ev_in == s2h_pkg::EV_MAKE) && !(|hit) && free[i] && !taken) begin
               slot_in[i] = usage;
               taken = 1'b1;
            end
            if ((ev_in == s2h_pkg::EV_BREAK) && hit[i] && !taken) begin
               slot_in[i] = 8'd0;
               taken = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (req_chan.ready) begin
         in_byte_ff <= req_chan.scan_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         state_ff <= s2h_pkg::ST_IDLE;
         mod_ff <= 8'd0;
         for (int i = 0; i < KEY_SLOTS; i++) begin
            slot_ff[i] <= 8'd0;
         end
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
         state_ff <= state_in;
         mod_ff <= mod_in;
         slot_ff <= slot_in;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         err_ff <= err_in;
         ev_ff <= ev_in;
      end
   end

   for (genvar j = 0; j < s2h_pkg::SHOWN_SLOTS; j++) begin : g_shown
      if (j < KEY_SLOTS) begin : g_kept
         assign shown[j] = slot_ff[j];
      end else begin : g_absent
         assign shown[j] = 8'd0;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.error_flag = err_ff;
   assign rsp_chan.key_event = ev_ff;
   assign rsp_chan.modifier_byte = mod_ff;
   assign rsp_chan.key_slot_0 = shown[0];
   assign rsp_chan.key_slot_1 = shown[1];
   assign rsp_chan.key_slot_2 = shown[2];
   assign rsp_chan.key_slot_3 = shown[3];
   assign rsp_chan.key_slot_4 = shown[4];
   assign rsp_chan.key_slot_5 = shown[5];

   `S2H_ASSERT_SAME(a_error_has_no_event, clock, reset,
      rsp_valid_ff && err_ff, ev_ff == s2h_pkg::EV_NONE)
   `S2H_ASSERT_NEXT(a_report_holds_when_idle, clock, reset,
      !advance, $stable(mod_ff) && $stable(state_ff))
   `S2H_ASSERT_NEXT(a_input_byte_holds_on_stall, clock, reset,
      in_valid_ff && !advance, in_valid_ff && $stable(in_byte_ff))

endmodule

`default_nettype wire
